>>> rtl/core/rrbd_pkg.sv
// Shared types, constants and codes for the reduced-round block digest.
package rrbd_pkg;

    localparam int unsigned HEAD_BYTES = 16;
    localparam int unsigned HEAD_WORDS = HEAD_BYTES / 4;
    localparam int unsigned CHAIN_WORDS = 8;

    localparam logic [1:0] ACT_ABSORB  = 2'd0;
    localparam logic [1:0] ACT_FINISH  = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic [5:0] LAST_BLOCK_BYTE = 6'd63;
    localparam logic [5:0] LEN_FIELD_START = 6'd56;
    localparam logic [7:0] PAD_MARK        = 8'h80;

    typedef logic [CHAIN_WORDS-1:0][31:0] t_vec;
    typedef logic [HEAD_WORDS-1:0][31:0]  t_msg;

    localparam t_msg ROUND_K = {
        32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
    };

    localparam t_vec CHAIN_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    typedef enum logic {
        OP_ROUND,
        OP_MIX
    } t_op;

    typedef enum logic {
        HM_RAW,
        HM_PAD
    } t_head_mode;

    typedef struct packed {
        logic       wr_en;
        logic [3:0] wr_idx;
        t_head_mode mode;
    } t_head_ctl;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
        logic        rejected;
    } t_out;

endpackage

>>> rtl/core/rrbd_head.sv
// Block head byte store with padding insertion for the final block.
module rrbd_head (
    input  logic                i_clk,
    input  rrbd_pkg::t_head_ctl i_ctl,
    input  logic [7:0]          i_byte,
    input  logic [5:0]          i_fill,
    output rrbd_pkg::t_msg      o_words
);

    logic [7:0] r_bytes [rrbd_pkg::HEAD_BYTES];
    logic [7:0] padded  [rrbd_pkg::HEAD_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_bytes[i_ctl.wr_idx] <= i_byte;
        end
    end

    // In pad mode: stored bytes, then the marker byte, then zeros.
    always_comb begin
        for (int i = 0; i < int'(rrbd_pkg::HEAD_BYTES); i++) begin
            if (i_ctl.mode == rrbd_pkg::HM_RAW || 6'(i) < i_fill) begin
                padded[i] = r_bytes[i];
            end else if (6'(i) == i_fill) begin
                padded[i] = rrbd_pkg::PAD_MARK;
            end else begin
                padded[i] = 8'h00;
            end
        end
        for (int r = 0; r < int'(rrbd_pkg::HEAD_WORDS); r++) begin
            o_words[r] = {padded[4*r], padded[4*r+1], padded[4*r+2], padded[4*r+3]};
        end
    end

endmodule

>>> rtl/core/rrbd_round.sv
// Shared round unit: one compression round or one rotate-xor mix step per cycle.
module rrbd_round (
    input  rrbd_pkg::t_op  i_op,
    input  logic [1:0]     i_rnd,
    input  logic [31:0]    i_w,
    input  rrbd_pkg::t_vec i_work,
    output rrbd_pkg::t_vec o_work
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] sig1, ch, t1, sig0, maj, t2;
    logic [31:0] m0, m2, m4, m6;

    assign a = i_work[0];
    assign b = i_work[1];
    assign c = i_work[2];
    assign d = i_work[3];
    assign e = i_work[4];
    assign f = i_work[5];
    assign g = i_work[6];
    assign h = i_work[7];

    assign sig1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    assign ch   = (e & f) ^ (~e & g);
    assign t1   = h + sig1 + ch + rrbd_pkg::ROUND_K[i_rnd] + i_w;
    assign sig0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    assign maj  = (a & b) ^ (a & c) ^ (b & c);
    assign t2   = sig0 + maj;

    // The mix words m4 and m6 use the words m0 and m2 produced just before them.
    assign m0 = a ^ rotr(e, 5);
    assign m2 = c ^ rotr(g, 11);
    assign m4 = e ^ rotr(m0, 7);
    assign m6 = g ^ rotr(m2, 13);

    always_comb begin
        unique case (i_op)
            rrbd_pkg::OP_ROUND: begin
                o_work[0] = t1 + t2;
                o_work[1] = a;
                o_work[2] = b;
                o_work[3] = c;
                o_work[4] = d + t1;
                o_work[5] = e;
                o_work[6] = f;
                o_work[7] = g;
            end
            rrbd_pkg::OP_MIX: begin
                o_work[0] = m0;
                o_work[1] = b;
                o_work[2] = m2;
                o_work[3] = d;
                o_work[4] = m4;
                o_work[5] = f;
                o_work[6] = m6;
                o_work[7] = h;
            end
            default: begin
                o_work = i_work;
            end
        endcase
    end

endmodule

>>> rtl/core/reduced_round_block_digest.sv
// Reduced-round block digest: absorbs bytes, compresses blocks, emits the digest.
// Each absorbed byte is taken while idle; the byte that completes a block then holds the
// block busy for 4 rounds and 2 mix steps on the shared round unit, then 1 feed-forward.
// A first finish compresses the padded block, plus a second block with a zero head when the
// padding spills; each finish shows four digest words, one per cycle while not stalled.
// Synchronous active-low reset loads the initial chain and clears all counters.
module reduced_round_block_digest (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  rrbd_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output rrbd_pkg::t_out o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_MIX,
        S_FEED,
        S_EMIT
    } t_state;

    t_state              r_state;
    rrbd_pkg::t_vec      r_chain;
    rrbd_pkg::t_vec      r_work;
    rrbd_pkg::t_vec      n_work;
    rrbd_pkg::t_msg      r_msg;
    rrbd_pkg::t_msg      n_msg;
    rrbd_pkg::t_msg      head_words;
    rrbd_pkg::t_vec      unit_out;
    rrbd_pkg::t_vec      feed_sum;
    rrbd_pkg::t_head_ctl head_ctl;
    rrbd_pkg::t_op       unit_op;
    logic [5:0]          r_fill;
    logic                r_finished;
    logic                r_out_valid;
    logic                r_rej;
    logic [1:0]          r_idx;
    logic [1:0]          r_rnd;
    logic                r_second;
    logic                r_fin_pending;
    logic                in_acc;
    logic                is_absorb;
    logic                is_finish;
    logic                start_cmp;
    logic [2:0]          hi_sel;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign is_absorb  = (i_in.action == rrbd_pkg::ACT_ABSORB);
    assign is_finish  = (i_in.action == rrbd_pkg::ACT_FINISH);
    assign start_cmp  = in_acc && !r_finished &&
                        ((is_absorb && r_fill == rrbd_pkg::LAST_BLOCK_BYTE) || is_finish);

    // Only the first sixteen bytes of a block reach the rounds.
    assign head_ctl.wr_en  = in_acc && is_absorb && !r_finished && (r_fill[5:4] == 2'b00);
    assign head_ctl.wr_idx = r_fill[3:0];
    assign head_ctl.mode   = is_finish ? rrbd_pkg::HM_PAD : rrbd_pkg::HM_RAW;

    rrbd_head u_head (
        .i_clk   (i_clk),
        .i_ctl   (head_ctl),
        .i_byte  (i_in.data_byte),
        .i_fill  (r_fill),
        .o_words (head_words)
    );

    assign unit_op = (r_state == S_MIX) ? rrbd_pkg::OP_MIX : rrbd_pkg::OP_ROUND;

    rrbd_round u_round (
        .i_op   (unit_op),
        .i_rnd  (r_rnd),
        .i_w    (r_msg[r_rnd]),
        .i_work (r_work),
        .o_work (unit_out)
    );

    always_comb begin
        for (int i = 0; i < int'(rrbd_pkg::CHAIN_WORDS); i++) begin
            feed_sum[i] = r_chain[i] + r_work[i];
        end
    end

    always_comb begin
        n_work = r_work;
        n_msg  = r_msg;
        case (r_state)
            S_IDLE: begin
                if (start_cmp) begin
                    n_work = r_chain;
                    n_msg  = head_words;
                end
            end
            S_ROUND, S_MIX: begin
                n_work = unit_out;
            end
            S_FEED: begin
                n_work = feed_sum;
                // The spill block carries only zeros in its head.
                if (r_second) begin
                    n_msg = '0;
                end
            end
            default: begin
                n_work = r_work;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_msg  <= n_msg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_chain       <= rrbd_pkg::CHAIN_IV;
            r_fill        <= '0;
            r_finished    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_rej         <= 1'b0;
            r_idx         <= '0;
            r_rnd         <= '0;
            r_second      <= 1'b0;
            r_fin_pending <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_in.action)
                            rrbd_pkg::ACT_ABSORB: begin
                                if (r_finished) begin
                                    r_rej       <= 1'b1;
                                    r_idx       <= '0;
                                    r_out_valid <= 1'b1;
                                    r_state     <= S_EMIT;
                                end else if (r_fill == rrbd_pkg::LAST_BLOCK_BYTE) begin
                                    r_fill        <= '0;
                                    r_rnd         <= '0;
                                    r_second      <= 1'b0;
                                    r_fin_pending <= 1'b0;
                                    r_state       <= S_ROUND;
                                end else begin
                                    r_fill <= r_fill + 6'd1;
                                end
                            end
                            rrbd_pkg::ACT_FINISH: begin
                                if (r_finished) begin
                                    r_rej       <= 1'b0;
                                    r_idx       <= '0;
                                    r_out_valid <= 1'b1;
                                    r_state     <= S_EMIT;
                                end else begin
                                    r_rnd         <= '0;
                                    r_second      <= (r_fill >= rrbd_pkg::LEN_FIELD_START);
                                    r_fin_pending <= 1'b1;
                                    r_state       <= S_ROUND;
                                end
                            end
                            rrbd_pkg::ACT_RESTART: begin
                                r_chain    <= rrbd_pkg::CHAIN_IV;
                                r_fill     <= '0;
                                r_finished <= 1'b0;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_ROUND: begin
                    if (r_rnd[0]) begin
                        r_state <= S_MIX;
                    end else begin
                        r_rnd <= r_rnd + 2'd1;
                    end
                end
                S_MIX: begin
                    if (r_rnd == 2'd3) begin
                        r_state <= S_FEED;
                    end else begin
                        r_rnd   <= r_rnd + 2'd1;
                        r_state <= S_ROUND;
                    end
                end
                S_FEED: begin
                    r_chain <= feed_sum;
                    r_rnd   <= '0;
                    if (r_second) begin
                        r_second <= 1'b0;
                        r_state  <= S_ROUND;
                    end else if (r_fin_pending) begin
                        r_fin_pending <= 1'b0;
                        r_fill        <= '0;
                        r_finished    <= 1'b1;
                        r_rej         <= 1'b0;
                        r_idx         <= '0;
                        r_out_valid   <= 1'b1;
                        r_state       <= S_EMIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (!i_out_stall) begin
                        if (r_rej || r_idx == 2'd3) begin
                            r_out_valid <= 1'b0;
                            r_rej       <= 1'b0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 2'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign hi_sel = {r_idx, 1'b0};

    assign o_out_valid       = r_out_valid;
    assign o_out.digest_word = r_rej ? 64'd0 : {r_chain[hi_sel], r_chain[hi_sel + 3'd1]};
    assign o_out.word_index  = r_idx;
    assign o_out.last_word   = !r_rej && (r_idx == 2'd3);
    assign o_out.rejected    = r_rej;

endmodule

>>> rtl/core/rrbd_checker.sv
// Port-level checks for the reduced-round block digest, bound to the top level.
module rrbd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input rrbd_pkg::t_out o_out
);

    // Hold a stalled transaction.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled output transaction changed");

    a_busy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while digest words pending");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.rejected |->
            o_out.digest_word == 64'd0 && o_out.word_index == 2'd0 && !o_out.last_word)
        else $error("reject transaction carries digest fields");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.last_word == (o_out.word_index == 2'd3 && !o_out.rejected)))
        else $error("last_word does not match fourth digest word");

    a_word_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out.rejected && !o_out.last_word |=>
            o_out_valid && o_out.word_index == 2'($past(o_out.word_index) + 2'd1))
        else $error("digest words not delivered in order");

endmodule

bind reduced_round_block_digest rrbd_checker u_rrbd_checker (.*);
